>>> sv/uelm_pkg.sv
// Package: constants, opcodes and the item record passed along the line cell chain.
package uelm_pkg;

	localparam int MAX_LINES = 64;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               op;
		logic signed [31:0] slope;
		logic signed [47:0] intercept;
		logic [15:0]        tag;
		logic signed [31:0] x;
		logic               pend;
		logic               found;
		logic signed [63:0] best_value;
		logic signed [31:0] best_slope;
		logic [15:0]        best_tag;
	} flow_t;

endpackage

>>> sv/uelm_req_if.sv
// Interface: input item channel (add or query).
interface uelm_req_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [31:0] slope;
	logic signed [47:0] intercept;
	logic [15:0]        tag;
	logic signed [31:0] query_x;

	modport source (output valid, output opcode, output slope, output intercept,
		output tag, output query_x, input ready);
	modport sink (input valid, input opcode, input slope, input intercept,
		input tag, input query_x, output ready);
endinterface

>>> sv/uelm_res_if.sv
// Interface: result item channel.
interface uelm_res_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] best_value;
	logic [15:0]        best_tag;
	logic               found;
	logic               table_full;

	modport source (output valid, output best_value, output best_tag, output found,
		output table_full, input ready);
	modport sink (input valid, input best_value, input best_tag, input found,
		input table_full, output ready);
endinterface

>>> sv/uelm_cell.sv
// Line cell: holds one line, stores a pending add, evaluates and merges queries over two stages.
module uelm_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            i_valid,
	input  uelm_pkg::flow_t i_flow,
	output logic            o_valid,
	output uelm_pkg::flow_t o_flow,
	output logic            have
);
	import uelm_pkg::*;

	logic               have_q;
	logic signed [31:0] slope_q;
	logic signed [47:0] icpt_q;
	logic [15:0]        tag_q;

	logic               valid_s1;
	flow_t              flow_s1;
	logic               have_s1;
	logic signed [31:0] slope_s1;
	logic signed [47:0] icpt_s1;
	logic [15:0]        tag_s1;
	logic signed [63:0] prod_s1;

	logic               take;
	logic signed [63:0] prod;
	logic signed [63:0] val;
	logic               hit;
	flow_t              nxt_s1;
	flow_t              nxt_s2;

	assign take = en && i_valid && (i_flow.op == OP_ADD) && i_flow.pend && !have_q;
	assign prod = slope_q * i_flow.x;
	assign have = have_q;

	always_comb begin
		nxt_s1 = i_flow;
		if (take) begin
			nxt_s1.pend = 1'b0;
		end
	end

	// stage 2: add intercept, compare with running best
	assign val = prod_s1 + {{16{icpt_s1[47]}}, icpt_s1};
	assign hit = (flow_s1.op == OP_QUERY) && have_s1 && (!flow_s1.found ||
		(val > flow_s1.best_value) ||
		((val == flow_s1.best_value) && (slope_s1 < flow_s1.best_slope)));

	always_comb begin
		nxt_s2 = flow_s1;
		if (hit) begin
			nxt_s2.found      = 1'b1;
			nxt_s2.best_value = val;
			nxt_s2.best_slope = slope_s1;
			nxt_s2.best_tag   = tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			valid_s1 <= 1'b0;
			o_valid  <= 1'b0;
		end else begin
			if (take) begin
				have_q <= 1'b1;
			end
			if (en) begin
				valid_s1 <= i_valid;
				o_valid  <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slope_q <= i_flow.slope;
			icpt_q  <= i_flow.intercept;
			tag_q   <= i_flow.tag;
		end
		if (en) begin
			flow_s1  <= nxt_s1;
			have_s1  <= have_q;
			slope_s1 <= slope_q;
			icpt_s1  <= icpt_q;
			tag_s1   <= tag_q;
			prod_s1  <= prod;
			o_flow   <= nxt_s2;
		end
	end

endmodule

>>> sv/upper_envelope_line_max.sv
// Top level: chain of MAX_LINES line cells with an output register.
// Every item, add or query, travels through a chain of MAX_LINES line cells, two
// stages per cell (multiply, then add and compare), and then an output register
// before its result appears. A new item is taken every cycle as long as the result
// side keeps up; a held result stalls the whole chain. An add is stored in the first
// empty cell it passes; if it leaves the chain unstored, its result has table_full
// set. A query carries the best value, slope and tag along the chain; ties go to the
// smaller slope, then to the earlier cell. No clearing pass is needed after reset.
module upper_envelope_line_max (
	input logic       clk,
	input logic       arst_n,
	uelm_req_if.sink  req,
	uelm_res_if.source res
);
	import uelm_pkg::*;

	logic                 en;
	logic                 valid_c [MAX_LINES+1];
	flow_t                flow_c  [MAX_LINES+1];
	logic [MAX_LINES-1:0] have_vec;
	flow_t                last;

	logic                 res_valid_q;
	logic signed [63:0]   value_q;
	logic [15:0]          tag_q;
	logic                 found_q;
	logic                 full_q;

	assign en        = !res_valid_q || res.ready;
	assign req.ready = en;

	always_comb begin
		flow_c[0]            = '0;
		flow_c[0].op         = req.opcode;
		flow_c[0].slope      = req.slope;
		flow_c[0].intercept  = req.intercept;
		flow_c[0].tag        = req.tag;
		flow_c[0].x          = req.query_x;
		flow_c[0].pend       = (req.opcode == OP_ADD);
	end
	assign valid_c[0] = req.valid;

	for (genvar k = 0; k < MAX_LINES; k++) begin : g_cell
		uelm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.i_valid (valid_c[k]),
			.i_flow  (flow_c[k]),
			.o_valid (valid_c[k+1]),
			.o_flow  (flow_c[k+1]),
			.have    (have_vec[k])
		);
	end

	assign last = flow_c[MAX_LINES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= valid_c[MAX_LINES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (last.op == OP_ADD) begin
				value_q <= '0;
				tag_q   <= '0;
				found_q <= 1'b0;
				full_q  <= last.pend;
			end else begin
				value_q <= last.best_value;
				tag_q   <= last.best_tag;
				found_q <= last.found;
				full_q  <= 1'b0;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.best_value = value_q;
	assign res.best_tag   = tag_q;
	assign res.found      = found_q;
	assign res.table_full = full_q;

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(found_q && full_q))
		else $error("found and table_full both set");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !found_q) |-> (value_q == '0 && tag_q == '0))
		else $error("result without a line is not zero");

	a_fill_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		((have_vec + 1'b1) & have_vec) == '0)
		else $error("cells not filled in order");

	a_fill_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((have_vec & $past(have_vec)) == $past(have_vec)))
		else $error("stored line lost");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && full_q) |-> have_vec[MAX_LINES-1])
		else $error("add dropped while a cell was free");

endmodule
